// File: rtl/sts_pkg.sv
`default_nettype none

package sts_pkg;

  // Counter and field widths
  localparam int unsigned POS_BITS    = 24;
  localparam int unsigned KW_CHARS    = 6;
  localparam int unsigned PREFIX_BITS = 8 * KW_CHARS;
  localparam int unsigned WLEN_BITS   = $clog2(KW_CHARS + 2);
  localparam int unsigned KIND_BITS   = 6;
  localparam int unsigned KW_COUNT    = 16;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // Result queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Token kinds
  localparam logic [KIND_BITS-1:0] KIND_LPAREN     = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN     = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE     = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE     = 6'd3;
  localparam logic [KIND_BITS-1:0] KIND_COMMA      = 6'd4;
  localparam logic [KIND_BITS-1:0] KIND_DOT        = 6'd5;
  localparam logic [KIND_BITS-1:0] KIND_MINUS      = 6'd6;
  localparam logic [KIND_BITS-1:0] KIND_PLUS       = 6'd7;
  localparam logic [KIND_BITS-1:0] KIND_STAR       = 6'd8;
  localparam logic [KIND_BITS-1:0] KIND_SEMI       = 6'd9;
  localparam logic [KIND_BITS-1:0] KIND_BANG       = 6'd10;
  localparam logic [KIND_BITS-1:0] KIND_BANG_EQ    = 6'd11;
  localparam logic [KIND_BITS-1:0] KIND_EQUAL      = 6'd12;
  localparam logic [KIND_BITS-1:0] KIND_EQ_EQ      = 6'd13;
  localparam logic [KIND_BITS-1:0] KIND_LESS       = 6'd14;
  localparam logic [KIND_BITS-1:0] KIND_LESS_EQ    = 6'd15;
  localparam logic [KIND_BITS-1:0] KIND_GREATER    = 6'd16;
  localparam logic [KIND_BITS-1:0] KIND_GREATER_EQ = 6'd17;
  localparam logic [KIND_BITS-1:0] KIND_STRING     = 6'd18;
  localparam logic [KIND_BITS-1:0] KIND_INT        = 6'd19;
  localparam logic [KIND_BITS-1:0] KIND_FRAC       = 6'd20;
  localparam logic [KIND_BITS-1:0] KIND_IDENT      = 6'd21;
  localparam logic [KIND_BITS-1:0] KIND_KEYWORD    = 6'd22;
  localparam logic [KIND_BITS-1:0] KIND_EOF        = 6'd38;
  localparam logic [KIND_BITS-1:0] KIND_ERROR      = 6'd39;

  // Source characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_CASE   = 8'h20;

  // Keyword text, first letter in the lowest byte, in kind order
  localparam logic [PREFIX_BITS-1:0] KW_TEXT [KW_COUNT] = '{
    PREFIX_BITS'(48'h00000000646E61),   // and
    PREFIX_BITS'(48'h007373616C63),     // class
    PREFIX_BITS'(48'h000065736C65),     // else
    PREFIX_BITS'(48'h0065736C6166),     // false
    PREFIX_BITS'(48'h000000726F66),     // for
    PREFIX_BITS'(48'h0000006E7566),     // fun
    PREFIX_BITS'(48'h000000006669),     // if
    PREFIX_BITS'(48'h00006C6C756E),     // null
    PREFIX_BITS'(48'h00000000726F),     // or
    PREFIX_BITS'(48'h00746E697270),     // print
    PREFIX_BITS'(48'h6E7275746572),     // return
    PREFIX_BITS'(48'h007265707573),     // super
    PREFIX_BITS'(48'h000073696874),     // this
    PREFIX_BITS'(48'h000065757274),     // true
    PREFIX_BITS'(48'h000000726176),     // var
    PREFIX_BITS'(48'h00656C696877)      // while
  };

  localparam logic [WLEN_BITS-1:0] KW_LEN [KW_COUNT] = '{
    WLEN_BITS'(3), WLEN_BITS'(5), WLEN_BITS'(4), WLEN_BITS'(5),
    WLEN_BITS'(3), WLEN_BITS'(3), WLEN_BITS'(2), WLEN_BITS'(4),
    WLEN_BITS'(2), WLEN_BITS'(5), WLEN_BITS'(6), WLEN_BITS'(5),
    WLEN_BITS'(4), WLEN_BITS'(4), WLEN_BITS'(3), WLEN_BITS'(5)
  };

  // One result item
  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [POS_BITS-1:0]  line;
    logic [POS_BITS-1:0]  start;
    logic [POS_BITS-1:0]  len;
    logic                 last;
    logic                 err;
  } sts_res_t;

  // Results of one byte, oldest in r0
  typedef struct packed {
    logic [1:0] num;
    sts_res_t   r1;
    sts_res_t   r0;
  } sts_push_t;

  // Queue status toward the scanner
  typedef struct packed {
    logic                 room;
    logic [QCNT_BITS-1:0] level;
  } sts_qstat_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    logic [7:0] l;
    l = c | CH_CASE;
    return (l >= CH_LOW_A) && (l <= CH_LOW_Z);
  endfunction

  // Identifier or keyword from the stored prefix and length
  function automatic logic [KIND_BITS-1:0] word_kind(logic [PREFIX_BITS-1:0] pref,
                                                     logic [WLEN_BITS-1:0]   wlen);
    logic [KIND_BITS-1:0] k;
    k = KIND_IDENT;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if ((wlen == KW_LEN[i]) && (pref == KW_TEXT[i])) begin
        k = KIND_KEYWORD + KIND_BITS'(i);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sts_scanner.sv
`default_nettype none

module sts_scanner (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              go_i,
  input  wire logic [7:0]        char_i,
  input  wire logic              fin_i,
  output sts_pkg::sts_push_t     push_o
);
  import sts_pkg::*;

  typedef enum logic [3:0] {
    M_IDLE, M_BANG, M_EQUAL, M_LESS, M_GREATER, M_STRING, M_INT, M_FRAC, M_IDENT
  } mode_e;

  mode_e                  mode_q, mode_d, mode_m, mode_f;
  logic [POS_BITS-1:0]    line_q, line_d, line_m, line_f;
  logic [POS_BITS-1:0]    pos_q, pos_d;
  logic [POS_BITS-1:0]    start_q, start_d, start_f;
  logic [PREFIX_BITS-1:0] pref_q, pref_d, pref_m, pref_f;
  logic [WLEN_BITS-1:0]   wlen_q, wlen_d, wlen_m, wlen_f;
  logic                   err_q, err_d;

  logic                   fresh;
  logic                   a_v, b_v, c_v;
  logic                   a_err, c_err;
  logic [KIND_BITS-1:0]   a_kind, b_kind, c_kind;
  logic [POS_BITS-1:0]    a_len, c_len;
  logic [POS_BITS-1:0]    incl, excl;
  sts_res_t               res_a, res_b, res_c;

  function automatic logic [POS_BITS-1:0] sat_len(logic [POS_BITS:0] v);
    return (v > {1'b0, POS_MAX}) ? POS_MAX : v[POS_BITS-1:0];
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] v);
    return (v < POS_MAX) ? v + 1'b1 : v;
  endfunction

  assign incl = sat_len({1'b0, pos_q} - {1'b0, start_q} + 1'b1);
  assign excl = pos_q - start_q;

  // Extend or close the pending token
  always_comb begin
    mode_m = mode_q;
    line_m = line_q;
    pref_m = pref_q;
    wlen_m = wlen_q;
    fresh  = 1'b0;
    a_v    = 1'b0;
    a_err  = 1'b0;
    a_kind = KIND_IDENT;
    a_len  = excl;
    unique case (mode_q)
      M_BANG, M_EQUAL, M_LESS, M_GREATER: begin
        a_v    = 1'b1;
        mode_m = M_IDLE;
        if (char_i == CH_EQ) begin
          a_len = incl;
          unique case (mode_q)
            M_BANG:  a_kind = KIND_BANG_EQ;
            M_EQUAL: a_kind = KIND_EQ_EQ;
            M_LESS:  a_kind = KIND_LESS_EQ;
            default: a_kind = KIND_GREATER_EQ;
          endcase
        end else begin
          fresh = 1'b1;
          unique case (mode_q)
            M_BANG:  a_kind = KIND_BANG;
            M_EQUAL: a_kind = KIND_EQUAL;
            M_LESS:  a_kind = KIND_LESS;
            default: a_kind = KIND_GREATER;
          endcase
        end
      end
      M_STRING: begin
        if (char_i == CH_QUOTE) begin
          a_v    = 1'b1;
          a_kind = KIND_STRING;
          a_len  = incl;
          mode_m = M_IDLE;
        end else if (char_i == CH_NUL) begin
          a_v    = 1'b1;
          a_kind = KIND_ERROR;
          a_err  = 1'b1;
          mode_m = M_IDLE;
          fresh  = 1'b1;
        end else if (char_i == CH_NL) begin
          line_m = sat_inc(line_q);
        end
      end
      M_INT: begin
        if (char_i == CH_DOT) begin
          mode_m = M_FRAC;
        end else if (!is_digit(char_i)) begin
          a_v    = 1'b1;
          a_kind = KIND_INT;
          mode_m = M_IDLE;
          fresh  = 1'b1;
        end
      end
      M_FRAC: begin
        if (!is_digit(char_i)) begin
          a_v    = 1'b1;
          a_kind = KIND_FRAC;
          mode_m = M_IDLE;
          fresh  = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_alpha(char_i)) begin
          for (int i = 0; i < KW_CHARS; i++) begin
            if (wlen_q == WLEN_BITS'(i)) pref_m[8*i +: 8] = char_i;
          end
          if (wlen_q <= WLEN_BITS'(KW_CHARS)) wlen_m = wlen_q + 1'b1;
        end else begin
          a_v    = 1'b1;
          a_kind = word_kind(pref_q, wlen_q);
          mode_m = M_IDLE;
          fresh  = 1'b1;
        end
      end
      default: begin
        mode_m = M_IDLE;
        fresh  = 1'b1;
      end
    endcase
  end

  // Scan the byte as the start of a new token
  always_comb begin
    mode_f  = mode_m;
    line_f  = line_m;
    start_f = start_q;
    pref_f  = pref_m;
    wlen_f  = wlen_m;
    b_v     = 1'b0;
    b_kind  = KIND_EOF;
    if (fresh) begin
      start_f = pos_q;
      b_v     = 1'b1;
      case (char_i)
        CH_NUL:    b_kind = KIND_EOF;
        CH_LPAREN: b_kind = KIND_LPAREN;
        CH_RPAREN: b_kind = KIND_RPAREN;
        CH_LBRACE: b_kind = KIND_LBRACE;
        CH_RBRACE: b_kind = KIND_RBRACE;
        CH_COMMA:  b_kind = KIND_COMMA;
        CH_DOT:    b_kind = KIND_DOT;
        CH_MINUS:  b_kind = KIND_MINUS;
        CH_PLUS:   b_kind = KIND_PLUS;
        CH_STAR:   b_kind = KIND_STAR;
        CH_SEMI:   b_kind = KIND_SEMI;
        default: begin
          b_v = 1'b0;
          if (char_i == CH_BANG) begin
            mode_f = M_BANG;
          end else if (char_i == CH_EQ) begin
            mode_f = M_EQUAL;
          end else if (char_i == CH_LT) begin
            mode_f = M_LESS;
          end else if (char_i == CH_GT) begin
            mode_f = M_GREATER;
          end else if (char_i == CH_QUOTE) begin
            mode_f = M_STRING;
          end else if (char_i == CH_NL) begin
            line_f = sat_inc(line_m);
          end else if (is_digit(char_i)) begin
            mode_f = M_INT;
          end else if (is_alpha(char_i)) begin
            mode_f = M_IDENT;
            pref_f = PREFIX_BITS'(char_i);
            wlen_f = WLEN_BITS'(1);
          end
        end
      endcase
    end
  end

  // Close whatever is still pending at the final byte
  always_comb begin
    c_v   = fin_i && (mode_f != M_IDLE);
    c_err = 1'b0;
    c_len = sat_len({1'b0, pos_q} - {1'b0, start_f} + 1'b1);
    unique case (mode_f)
      M_BANG:    c_kind = KIND_BANG;
      M_EQUAL:   c_kind = KIND_EQUAL;
      M_LESS:    c_kind = KIND_LESS;
      M_GREATER: c_kind = KIND_GREATER;
      M_STRING: begin
        c_kind = KIND_ERROR;
        c_err  = c_v;
      end
      M_INT:     c_kind = KIND_INT;
      M_FRAC:    c_kind = KIND_FRAC;
      default:   c_kind = word_kind(pref_f, wlen_f);
    endcase
  end

  // Build the results in order and the next state
  always_comb begin
    res_a = '{kind: a_kind, line: line_m, start: start_q, len: a_len,
              last: 1'b0, err: err_q | a_err};
    res_b = '{kind: b_kind, line: line_m, start: pos_q, len: POS_BITS'(1),
              last: 1'b0, err: err_q | a_err};
    res_c = '{kind: c_kind, line: line_m, start: start_f, len: c_len,
              last: 1'b0, err: err_q | a_err | c_err};

    push_o.num = go_i ? (2'(a_v) + 2'(b_v) + 2'(c_v)) : 2'd0;
    push_o.r0  = a_v ? res_a : (b_v ? res_b : res_c);
    push_o.r1  = (a_v && b_v) ? res_b : res_c;
    push_o.r0.last = (push_o.num == 2'd1);
    push_o.r1.last = 1'b1;

    err_d  = err_q | a_err | c_err;
    pref_d = pref_f;
    wlen_d = wlen_f;
    if (fin_i) begin
      mode_d  = M_IDLE;
      line_d  = POS_BITS'(1);
      pos_d   = '0;
      start_d = '0;
    end else begin
      mode_d  = mode_f;
      line_d  = line_f;
      pos_d   = sat_inc(pos_q);
      start_d = start_f;
    end
  end

  // Hold scan state, advance on each request taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      line_q  <= POS_BITS'(1);
      pos_q   <= '0;
      start_q <= '0;
      pref_q  <= '0;
      wlen_q  <= '0;
      err_q   <= 1'b0;
    end else if (go_i) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      pref_q  <= pref_d;
      wlen_q  <= wlen_d;
      err_q   <= err_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sts_res_queue.sv
`default_nettype none

module sts_res_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  sts_pkg::sts_push_t   push_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output sts_pkg::sts_res_t    res_o,
  output sts_pkg::sts_qstat_t  stat_o
);
  import sts_pkg::*;

  sts_res_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q;
  logic                 pop;
  logic                 two;

  assign pop         = valid_o && ready_i;
  assign two         = (push_i.num == 2'd2);
  assign valid_o     = (cnt_q != '0);
  assign res_o       = mem_q[rd_q];
  assign stat_o.room = (cnt_q <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign stat_o.level = cnt_q;

  // Store up to two results per cycle
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (two) mem_q[wr_q + 1'b1] <= push_i.r1;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + QPTR_BITS'(push_i.num);
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCNT_BITS'(push_i.num) - QCNT_BITS'(pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/script_token_scanner.sv
`default_nettype none

// Channel   Dir  Signals                     Content
// s_axis    in   tvalid tready tdata tlast   source byte, tlast marks final byte
// m_axis    out  tvalid tready tdata tuser   one token, tuser = kind,
//                tlast                       tlast marks last token of a byte
//
// One source byte per cycle, while the queue has room, is taken into an
// input register and scanned from there; each byte yields zero, one or
// two tokens. Tokens drain at one per cycle while m_axis_tready is high,
// from a four-entry queue; a byte is scanned only while the queue has room
// for two, so bursts of two-token bytes slow intake to the output rate.
// Reset (rst_ni low, asynchronous) empties the queue and returns the scanner
// to idle, line 1, offset 0, error flag clear.
module script_token_scanner (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // final_char
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // [23:0] line_number, [47:24] start_offset,
                                           // [71:48] token_length, [72] error_seen,
                                           // [79:73] zero
  output logic [5:0]       m_axis_tuser,   // [5:0] token_kind
  output logic             m_axis_tlast    // last_of_run
);
  import sts_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_fin_q;
  logic       go;
  logic       take;
  sts_push_t  push;
  sts_res_t   head;
  sts_qstat_t qstat;

  assign go            = in_valid_q && qstat.room;
  assign s_axis_tready = !in_valid_q || go;
  assign take          = s_axis_tvalid && s_axis_tready;

  // Hold the incoming request until the scanner takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (go) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_char_q <= s_axis_tdata;
      in_fin_q  <= s_axis_tlast;
    end
  end

  sts_scanner u_scanner (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .char_i (in_char_q),
    .fin_i  (in_fin_q),
    .push_o (push)
  );

  sts_res_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (head),
    .stat_o  (qstat)
  );

  // Pack the queue head onto the stream
  assign m_axis_tdata = {7'd0, head.err, head.len, head.start, head.line};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // Queue never overfills
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.level <= QCNT_BITS'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  // A scan step only runs with room for two results
  a_go_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.num != 2'd0) |-> (qstat.level <= QCNT_BITS'(QUEUE_DEPTH - 2)))
    else $error("results pushed without room");

  // Results are only produced for a taken byte
  a_push_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.num != 2'd0) |-> go)
    else $error("results pushed without a byte");

  // Paired results carry the last mark only on the second
  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.num == 2'd2) |-> (!push.r0.last && push.r1.last))
    else $error("wrong last mark on paired results");

endmodule

`default_nettype wire
